[design/sida_pkg.sv]
// Shared constants, types and state codes for the signed integer to decimal text block.
`timescale 1ns / 1ps

package sida_pkg;

    // Width of the signed input value
    localparam int VALUE_WIDTH = 32;

    // Decimal digits that always cover a magnitude of up to 2^(VALUE_WIDTH-1)
    localparam int DIGIT_COUNT = (VALUE_WIDTH * 3) / 10 + 1;
    localparam int BCD_WIDTH   = DIGIT_COUNT * 4;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);
    localparam int IDX_WIDTH   = $clog2(DIGIT_COUNT);

    // Character codes
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef logic [BCD_WIDTH-1:0]   bcd_t;
    typedef logic [VALUE_WIDTH-1:0] mag_t;
    typedef logic [IDX_WIDTH-1:0]   idx_t;

    // Emission sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_DIGITS
    } state_t;

endpackage

[design/sida_bin2bcd.sv]
// Iterative binary to BCD converter: one add-3 and shift step per clock.
`timescale 1ns / 1ps

module sida_bin2bcd
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  sida_pkg::mag_t mag,
    output logic          done,
    output sida_pkg::bcd_t bcd
);
    import sida_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic [CNT_WIDTH-1:0] cnt_next;
    bcd_t                 bcd_reg;
    bcd_t                 bcd_next;
    mag_t                 bin_reg;
    mag_t                 bin_next;
    bcd_t                 bcd_adj;

    // Add 3 to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    // Step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bcd_next  = bcd_reg;
        bin_next  = bin_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_WIDTH'(VALUE_WIDTH - 1);
            bcd_next  = '0;
            bin_next  = mag;
        end
        else if (busy_reg)
        begin
            bcd_next = {bcd_adj[BCD_WIDTH-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

[design/signed_int_to_decimal_ascii.sv]
// Top level: signed integer in, decimal ASCII characters out, one per item.
`timescale 1ns / 1ps

// Takes one signed VALUE_WIDTH-bit integer per input item and sends its decimal
// text as ASCII, most significant character first: '-' for a negative value,
// then the digits with leading zeros dropped (zero gives a single '0'). The
// final character of each number has tlast set. One number is handled at a
// time: the magnitude goes through an iterative binary to BCD converter that
// does one add-3 and shift step per clock, VALUE_WIDTH steps in all, and the
// characters then leave one per cycle from an output register while m_tready
// does not stall them. The minus sign of a negative value goes out in the
// cycle a positive value spends picking its first digit. s_tready is high
// only while no number is in progress; the last character may still wait
// in the output register while the next number is accepted.
module signed_int_to_decimal_ascii
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic signed [sida_pkg::VALUE_WIDTH-1:0] s_tdata,  // [31:0] value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,  // [7:0] char_code
    output logic                                m_tlast   // last
);
    import sida_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic       neg_reg;
    logic       neg_next;
    idx_t       idx_reg;
    idx_t       idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_char_reg;
    logic [7:0] out_char_next;
    logic       out_last_reg;
    logic       out_last_next;

    logic       accept;
    logic       slot_free;
    logic       conv_start;
    logic       conv_done;
    mag_t       mag_in;
    bcd_t       bcd;
    idx_t       lead_idx;
    logic [3:0] digit;

    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;

    // Magnitude one's complement plus one; the most negative value maps exactly
    assign mag_in = s_tdata[VALUE_WIDTH-1] ? (~$unsigned(s_tdata) + 1'b1)
                                           : $unsigned(s_tdata);
    assign conv_start = accept;

    sida_bin2bcd u_bin2bcd
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .mag   (mag_in),
        .done  (conv_done),
        .bcd   (bcd)
    );

    // Highest non-zero digit, or the units digit for zero
    always_comb
    begin
        lead_idx = '0;
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            if (bcd[i*4 +: 4] != 4'd0)
            begin
                lead_idx = IDX_WIDTH'(i);
            end
        end
    end

    assign digit = bcd[idx_reg*4 +: 4];

    // Sequencer and output register loading
    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        idx_next       = idx_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        s_tready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    neg_next   = s_tdata[VALUE_WIDTH-1];
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (conv_done)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                idx_next = lead_idx;
                if (!neg_reg)
                begin
                    state_next = ST_DIGITS;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO + {4'd0, digit};
                    out_last_next  = (idx_reg == '0);
                    idx_next       = idx_reg - 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        idx_reg      <= idx_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    a_done_in_convert: assert property (@(posedge clk) disable iff (!rst_n)
        conv_done |-> (state_reg == ST_CONVERT))
        else $error("converter finished outside the convert state");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == CHAR_MINUS ||
                      (m_tdata >= CHAR_ZERO && m_tdata <= CHAR_ZERO + 8'd9)))
        else $error("character is neither a minus sign nor a digit");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata == CHAR_MINUS) |-> !m_tlast)
        else $error("minus sign flagged as last character");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONVERT) |-> !s_tready)
        else $error("input ready during conversion");

endmodule

[dv/signed_int_to_decimal_ascii_tb.sv]
// Self-checking testbench for the signed integer to decimal ASCII text block.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;

    import sida_pkg::*;

    // Cycles with no item moving on either side before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // Cycles allowed after the last character for any stray output
    localparam int TAIL_CYCLES = 60;
    // Items at the end of the run that go through with no idling
    localparam int QUIET_TAIL  = 25;
    localparam int RANDOM_ITEMS = 110;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    typedef struct {
        mag_t value;
        bit   drain;   // hold off until every character so far has arrived
    } number_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    mag_t       s_tdata = '0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    number_item_t numbers_q[$];
    text_char_t   expected_chars[$];
    int           send_gap;
    int           recv_gap;
    bit           quiet = 1'b0;
    int           idle_cycles = 0;
    int           errors = 0;

    signed_int_to_decimal_ascii dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Decimal text of one number, pushed as expected characters
    function automatic void predict_text(mag_t value);
        logic [VALUE_WIDTH:0] mag;
        logic [3:0]           digits[24];
        int                   nd;
        bit                   neg;
        text_char_t           ch;
        neg = value[VALUE_WIDTH-1];
        // one bit wider, so the most negative value keeps its magnitude
        mag = neg ? (~{1'b1, value} + 1'b1) : {1'b0, value};
        nd = 0;
        do
        begin
            digits[nd] = 4'(mag % 10);
            mag = mag / 10;
            nd++;
        end
        while (mag != 0);
        if (neg)
        begin
            ch.code = CHAR_MINUS;
            ch.last = 1'b0;
            expected_chars.push_back(ch);
        end
        for (int d = nd - 1; d >= 0; d--)
        begin
            ch.code = CHAR_ZERO + 8'(digits[d]);
            ch.last = (d == 0);
            expected_chars.push_back(ch);
        end
    endfunction

    // Random number: mostly a random count of digits, some full-width patterns
    function automatic mag_t random_number();
        longint unsigned span;
        longint unsigned mag;
        int              pick;
        int              ndig;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return mag_t'($urandom);
        ndig = $urandom_range(1, 10);
        span = 1;
        for (int i = 0; i < ndig; i++)
            span = span * 10;
        mag = {$urandom, $urandom} % span;
        if (mag > 64'h8000_0000)
            mag = mag % 64'h8000_0000;
        if ($urandom_range(0, 1) == 1)
            return mag_t'(-longint'(mag));
        return mag_t'(mag);
    endfunction

    // Driver: presents queued numbers, with random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
            quiet    <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_text(s_tdata);
            quiet <= (numbers_q.size() <= QUIET_TAIL);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (numbers_q.size() != 0 &&
                         !(numbers_q[0].drain && expected_chars.size() != 0))
                begin
                    if (!quiet && $urandom_range(0, 4) == 0)
                    begin
                        send_gap <= $urandom_range(0, 4);
                        s_tvalid <= 1'b0;
                    end
                    else
                    begin
                        s_tdata  <= numbers_q[0].value;
                        s_tvalid <= 1'b1;
                        numbers_q.pop_front();
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each character against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        text_char_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected character: char_code %0d last %0b", m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== want.code)
                    begin
                        $error("char_code: expected %0d, got %0d", want.code, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (recv_gap != 0)
            begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                recv_gap <= $urandom_range(0, 4);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles in which no item moves on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus and end of run
    initial
    begin
        mag_t         directed[$];
        number_item_t item;
        bit           finished;
        bit           timed_out;
        finished  = 1'b0;
        timed_out = 1'b0;

        // extremes, zero, digit-count boundaries and the most negative value
        directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
                     32'sd99, 32'sd100, 32'sd999999999, -32'sd999999999,
                     32'sd1000000000, -32'sd1000000000, 32'sd1234567890,
                     -32'sd1234567890, 32'sd2000000000, 32'h5555_5555,
                     32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000};
        foreach (directed[i])
        begin
            item.value = directed[i];
            item.drain = 1'b0;
            numbers_q.push_back(item);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            item.value = random_number();
            item.drain = (i == 0 || i == RANDOM_ITEMS / 2);
            numbers_q.push_back(item);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (!finished && !timed_out)
        begin
            @(negedge clk);
            if (numbers_q.size() == 0 && !s_tvalid && expected_chars.size() == 0)
                finished = 1'b1;
            if (idle_cycles >= STALL_LIMIT)
                timed_out = 1'b1;
        end
        if (!timed_out)
            repeat (TAIL_CYCLES) @(negedge clk);
        if (expected_chars.size() != 0)
        begin
            $error("%0d expected characters never arrived", expected_chars.size());
            errors++;
        end

        if (!timed_out && errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
design/sida_pkg.sv
design/sida_bin2bcd.sv
design/signed_int_to_decimal_ascii.sv
dv/signed_int_to_decimal_ascii_tb.sv
